FILE: rtl/g2g_pkg.sv
// ----------------------------------------------------------------------------
// Go-to-goal controller package
// Shared widths, register indexes, payload layout and the arctangent table.
// ----------------------------------------------------------------------------
package g2g_pkg;

   // Field widths (Q7.16 fixed point unless noted).
   localparam int FRAC_BITS = 16;
   localparam int POSE_W    = 24;
   localparam int HEAD_W    = 19;
   localparam int TGT_W     = 20;
   localparam int GAIN_W    = 21;
   localparam int LIN_W     = 21;
   localparam int ANG_W     = 19;
   localparam int CSR_W     = 21;
   localparam int CSR_IDX_W = 3;

   // Internal datapath widths.
   localparam int OFF_W         = POSE_W + 1;
   localparam int SQ_W          = 2 * POSE_W;
   localparam int DIST_W        = POSE_W;
   localparam int SQRT_STAGES   = DIST_W;
   localparam int CORDIC_STAGES = 16;
   localparam int PRESCALE      = 20;
   localparam int CX_W          = 48;
   localparam int ANG_FRAC      = 30;
   localparam int CZ_W          = 34;
   localparam int ROUND_SH      = ANG_FRAC - FRAC_BITS;
   localparam int BEAR_W        = 20;
   localparam int ERR_W         = 21;
   localparam int PROD_W        = GAIN_W + DIST_W;
   localparam int PIPE_DEPTH    = SQRT_STAGES + 5;

   localparam logic signed [CZ_W-1:0] HALF_PI_Q30 = CZ_W'(64'd1686629713);
   localparam logic [ERR_W-1:0] ANG_FIELD_MAX = ERR_W'((1 << ANG_W) - 1);

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_GAIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_LIMIT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DISTANCE_GATE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_GATE    = 3'd5;

   // atan(2^-i) in Q30 radians.
   localparam logic [30:0] ATAN_Q30 [24] = '{
      31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159,
      31'd67021687,  31'd33543516,  31'd16775851,  31'd8388437,
      31'd4194283,   31'd2097141,   31'd1048575,   31'd524288,
      31'd262144,    31'd131072,    31'd65536,     31'd32768,
      31'd16384,     31'd8192,      31'd4096,      31'd2048,
      31'd1024,      31'd512,       31'd256,       31'd128
   };

   // One pose sample.
   typedef struct packed {
      logic signed [POSE_W-1:0] pose_x;
      logic signed [POSE_W-1:0] pose_y;
      logic signed [HEAD_W-1:0] pose_heading;
   } pose_type;

   // One velocity command.
   typedef struct packed {
      logic [LIN_W-1:0] linear_speed;
      logic [ANG_W-1:0] angular_rate;
   } cmd_type;

endpackage

FILE: rtl/g2g_pose_if.sv
// ----------------------------------------------------------------------------
// Pose channel
// Valid/ready channel that carries one pose sample per transfer.
// ----------------------------------------------------------------------------
interface g2g_pose_if;
   logic                             valid;
   logic                             ready;
   logic signed [g2g_pkg::POSE_W-1:0] pose_x;
   logic signed [g2g_pkg::POSE_W-1:0] pose_y;
   logic signed [g2g_pkg::HEAD_W-1:0] pose_heading;

   modport source (output valid, pose_x, pose_y, pose_heading, input ready);
   modport sink   (input valid, pose_x, pose_y, pose_heading, output ready);
endinterface

FILE: rtl/g2g_cmd_if.sv
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one velocity command per transfer.
// ----------------------------------------------------------------------------
interface g2g_cmd_if;
   logic                       valid;
   logic                       ready;
   logic [g2g_pkg::LIN_W-1:0]  linear_speed;
   logic [g2g_pkg::ANG_W-1:0]  angular_rate;

   modport source (output valid, linear_speed, angular_rate, input ready);
   modport sink   (input valid, linear_speed, angular_rate, output ready);
endinterface

FILE: rtl/go_to_goal_velocity_control.sv
// ----------------------------------------------------------------------------
// Go-to-goal velocity controller
// Turns pose samples into linear speed and turn rate commands toward a target.
// ----------------------------------------------------------------------------
// The block accepts one pose sample per clock while it advances and
// returns one command per sample, in order. The depth of the pipeline is set
// by the square root, which resolves one root bit per stage over 24 stages;
// the bearing CORDIC runs alongside it in the first CORDIC_STAGES of them.
// The whole pipeline advances together, so it stalls only while a finished
// command waits at the output and the sink is not ready. Write the target
// and gate registers only while no samples are in flight.
module go_to_goal_velocity_control (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [g2g_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [g2g_pkg::CSR_W-1:0]      csr_data,
   g2g_pose_if.sink                       req,
   g2g_cmd_if.source                      rsp
);

   typedef struct packed {
      logic [g2g_pkg::SQ_W-1:0]          rem;
      logic [g2g_pkg::DIST_W-1:0]        root;
      logic signed [g2g_pkg::CX_W-1:0]   cx;
      logic signed [g2g_pkg::CX_W-1:0]   cy;
      logic signed [g2g_pkg::CZ_W-1:0]   cz;
      logic signed [g2g_pkg::HEAD_W-1:0] hd;
   } iter_type;

   // Configuration registers.
   logic [g2g_pkg::TGT_W-1:0]  target_x_ff, target_y_ff;
   logic [g2g_pkg::GAIN_W-1:0] speed_gain_ff, speed_limit_ff, distance_gate_ff;
   logic [g2g_pkg::ANG_W-1:0]  angle_gate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_x_ff      <= g2g_pkg::TGT_W'(65536);
         target_y_ff      <= g2g_pkg::TGT_W'(65536);
         speed_gain_ff    <= g2g_pkg::GAIN_W'(65536);
         speed_limit_ff   <= g2g_pkg::GAIN_W'(65536);
         distance_gate_ff <= g2g_pkg::GAIN_W'(6554);
         angle_gate_ff    <= g2g_pkg::ANG_W'(13107);
      end else if (csr_we) begin
         unique case (csr_index)
            g2g_pkg::REG_TARGET_X:      target_x_ff <= csr_data[g2g_pkg::TGT_W-1:0];
            g2g_pkg::REG_TARGET_Y:      target_y_ff <= csr_data[g2g_pkg::TGT_W-1:0];
            g2g_pkg::REG_SPEED_GAIN:    speed_gain_ff <= csr_data;
            g2g_pkg::REG_SPEED_LIMIT:   speed_limit_ff <= csr_data;
            g2g_pkg::REG_DISTANCE_GATE: distance_gate_ff <= csr_data;
            g2g_pkg::REG_ANGLE_GATE:    angle_gate_ff <= csr_data[g2g_pkg::ANG_W-1:0];
            default: ;
         endcase
      end
   end

   // Global advance: every stage moves unless the output holds a command that the sink has not taken.
   logic advance;
   logic [g2g_pkg::PIPE_DEPTH-1:0] vld_ff;

   assign advance   = !vld_ff[g2g_pkg::PIPE_DEPTH-1] || rsp.ready;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[g2g_pkg::PIPE_DEPTH-2:0], req.valid};
      end
   end

   // Stage 0: offsets to the target.
   logic signed [g2g_pkg::OFF_W-1:0]  dx_ff, dy_ff;
   logic signed [g2g_pkg::HEAD_W-1:0] hd0_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff  <= $signed({5'd0, target_x_ff}) - $signed({req.pose_x[g2g_pkg::POSE_W-1],
                                                          req.pose_x});
         dy_ff  <= $signed({5'd0, target_y_ff}) - $signed({req.pose_y[g2g_pkg::POSE_W-1],
                                                          req.pose_y});
         hd0_ff <= req.pose_heading;
      end
   end

   // Stage 1: squares, and the CORDIC quadrant pre-rotation.
   logic signed [2*g2g_pkg::OFF_W-1:0] sqx_full, sqy_full;
   logic [g2g_pkg::SQ_W-1:0]           sqx_ff, sqy_ff;
   logic signed [g2g_pkg::CX_W-1:0]    x0, y0, rx_in, ry_in, rx_ff, ry_ff;
   logic signed [g2g_pkg::CZ_W-1:0]    rz_in, rz_ff;
   logic signed [g2g_pkg::HEAD_W-1:0]  hd1_ff;

   assign sqx_full = dx_ff * dx_ff;
   assign sqy_full = dy_ff * dy_ff;
   assign x0 = g2g_pkg::CX_W'(dx_ff) <<< g2g_pkg::PRESCALE;
   assign y0 = g2g_pkg::CX_W'(dy_ff) <<< g2g_pkg::PRESCALE;

   always_comb begin
      rx_in = x0;
      ry_in = y0;
      rz_in = '0;
      if (x0 < 0) begin
         if (y0 >= 0) begin
            rx_in = y0;
            ry_in = -x0;
            rz_in = g2g_pkg::HALF_PI_Q30;
         end else begin
            rx_in = -y0;
            ry_in = x0;
            rz_in = -g2g_pkg::HALF_PI_Q30;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sqx_ff <= sqx_full[g2g_pkg::SQ_W-1:0];
         sqy_ff <= sqy_full[g2g_pkg::SQ_W-1:0];
         rx_ff  <= rx_in;
         ry_ff  <= ry_in;
         rz_ff  <= rz_in;
         hd1_ff <= hd0_ff;
      end
   end

   // Stage 2 onward: square root one bit per stage, CORDIC one step per stage for the first CORDIC_STAGES stages.
   iter_type pipe_ff [g2g_pkg::SQRT_STAGES+1];
   iter_type pipe_in [g2g_pkg::SQRT_STAGES+1];

   always_comb begin
      pipe_in[0].rem  = sqx_ff + sqy_ff;
      pipe_in[0].root = '0;
      pipe_in[0].cx   = rx_ff;
      pipe_in[0].cy   = ry_ff;
      pipe_in[0].cz   = rz_ff;
      pipe_in[0].hd   = hd1_ff;
   end

   for (genvar j = 0; j < g2g_pkg::SQRT_STAGES; j++) begin : g_iter
      localparam int BITPOS = g2g_pkg::SQRT_STAGES - 1 - j;
      logic [g2g_pkg::SQ_W-1:0] trial;

      always_comb begin
         pipe_in[j+1] = pipe_ff[j];
         trial = (g2g_pkg::SQ_W'(pipe_ff[j].root) << (BITPOS + 1))
               | (g2g_pkg::SQ_W'(1) << (2 * BITPOS));
         if (pipe_ff[j].rem >= trial) begin
            pipe_in[j+1].rem  = pipe_ff[j].rem - trial;
            pipe_in[j+1].root = pipe_ff[j].root | (g2g_pkg::DIST_W'(1) << BITPOS);
         end
         if (j < g2g_pkg::CORDIC_STAGES) begin
            if ($signed(pipe_ff[j].cy) > 0) begin
               pipe_in[j+1].cx = $signed(pipe_ff[j].cx) + ($signed(pipe_ff[j].cy) >>> j);
               pipe_in[j+1].cy = $signed(pipe_ff[j].cy) - ($signed(pipe_ff[j].cx) >>> j);
               pipe_in[j+1].cz = $signed(pipe_ff[j].cz)
                               + $signed({3'd0, g2g_pkg::ATAN_Q30[j]});
            end else begin
               pipe_in[j+1].cx = $signed(pipe_ff[j].cx) - ($signed(pipe_ff[j].cy) >>> j);
               pipe_in[j+1].cy = $signed(pipe_ff[j].cy) + ($signed(pipe_ff[j].cx) >>> j);
               pipe_in[j+1].cz = $signed(pipe_ff[j].cz)
                               - $signed({3'd0, g2g_pkg::ATAN_Q30[j]});
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff <= pipe_in;
      end
   end

   // Post stage A: bearing error, gates and the speed product.
   iter_type                          last;
   logic signed [g2g_pkg::CZ_W-1:0]   z_round, z_shift;
   logic signed [g2g_pkg::ERR_W-1:0]  err;
   logic [g2g_pkg::ERR_W-1:0]         aerr;
   logic [g2g_pkg::ANG_W-1:0]         aerr_sat_ff;
   logic                              far_ff, turn_ff;
   logic [g2g_pkg::PROD_W-1:0]        prod_ff;

   assign last    = pipe_ff[g2g_pkg::SQRT_STAGES];
   assign z_round = $signed(last.cz) + (g2g_pkg::CZ_W'(1) << (g2g_pkg::ROUND_SH - 1));
   assign z_shift = z_round >>> g2g_pkg::ROUND_SH;
   assign err     = $signed(z_shift[g2g_pkg::ERR_W-1:0])
                  - $signed({{2{last.hd[g2g_pkg::HEAD_W-1]}}, last.hd});
   assign aerr    = err[g2g_pkg::ERR_W-1] ? g2g_pkg::ERR_W'(-err) : g2g_pkg::ERR_W'(err);

   always_ff @(posedge clock) begin
      if (advance) begin
         far_ff      <= last.root > g2g_pkg::DIST_W'(distance_gate_ff);
         turn_ff     <= aerr > g2g_pkg::ERR_W'(angle_gate_ff);
         aerr_sat_ff <= (aerr > g2g_pkg::ANG_FIELD_MAX) ? '1 : aerr[g2g_pkg::ANG_W-1:0];
         prod_ff     <= g2g_pkg::PROD_W'(speed_gain_ff) * g2g_pkg::PROD_W'(last.root);
      end
   end

   // Post stage B: pick stop, turn or drive and saturate the speed.
   logic [g2g_pkg::PROD_W-1:0] lin_full;
   logic [g2g_pkg::LIN_W-1:0]  lin_in, lin_ff;
   logic [g2g_pkg::ANG_W-1:0]  ang_in, ang_ff;

   assign lin_full = prod_ff >> g2g_pkg::FRAC_BITS;

   always_comb begin
      lin_in = '0;
      ang_in = '0;
      if (far_ff) begin
         if (turn_ff) begin
            ang_in = aerr_sat_ff;
         end else if (lin_full > g2g_pkg::PROD_W'(speed_limit_ff)) begin
            lin_in = speed_limit_ff;
         end else begin
            lin_in = lin_full[g2g_pkg::LIN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lin_ff <= lin_in;
         ang_ff <= ang_in;
      end
   end

   assign rsp.valid        = vld_ff[g2g_pkg::PIPE_DEPTH-1];
   assign rsp.linear_speed = lin_ff;
   assign rsp.angular_rate = ang_ff;

endmodule
